/* design/mal_pkg.sv */
package mal_pkg;

  // Item command codes
  localparam logic [2:0] CMD_SAMPLE = 3'd0;
  localparam logic [2:0] CMD_PRESS  = 3'd1;
  localparam logic [2:0] CMD_STOP   = 3'd2;
  localparam logic [2:0] CMD_UNDO   = 3'd3;
  localparam logic [2:0] CMD_RESET  = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] CFG_LEVEL = 2'd0;
  localparam logic [1:0] CFG_BAR   = 2'd1;
  localparam logic [1:0] CFG_BCNT  = 2'd2;

  // Fixed field widths
  localparam int W_CMD    = 3;
  localparam int W_SAMPLE = 16;
  localparam int W_AUDIO  = 21;
  localparam int W_MODE   = 3;
  localparam int W_LCNT   = 4;
  localparam int W_POS    = 22;
  localparam int W_LEVEL  = 16;
  localparam int W_BAR    = 22;
  localparam int W_BCNT   = 6;
  localparam int W_CFGIDX = 2;

  // Mix arithmetic constants
  localparam int LEVEL_RESET = 16384;
  localparam int LEVEL_MAX   = 32768;
  localparam int MIX_FRAC    = 14;
  localparam int MIX_ROUND   = 8192;
  localparam int AUDIO_MAX   = 1048575;
  localparam int AUDIO_MIN   = -1048576;

  typedef enum logic [2:0] {
    MODE_EMPTY = 3'd0,
    MODE_REC   = 3'd1,
    MODE_PLAY  = 3'd2,
    MODE_DUB   = 3'd3,
    MODE_STOP  = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DEC,
    ST_DIV,
    ST_LEN,
    ST_READ,
    ST_ACC,
    ST_MUL,
    ST_FIN
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load;
    logic dec;
    logic div_init;
    logic div_step;
    logic len_en;
    logic rd_en;
    logic mul_en;
    logic fin;
  } ctl_cmd_t;

  // Status from datapath to controller
  typedef struct packed {
    logic is_sample;
    logic mix_req;
    logic close_req;
    logic snap;
    logic out_free;
  } dp_sts_t;

endpackage

/* design/mal_ctrl.sv */
module mal_ctrl #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_LEN    = 2097152
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  mal_pkg::dp_sts_t    sts,
  output mal_pkg::ctl_cmd_t   cmd,
  output logic [((MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1)-1:0] rd_idx
);

  localparam int HW = $clog2(MAX_LEN + 1);
  localparam int DW = ((HW > mal_pkg::W_BAR) ? HW : mal_pkg::W_BAR) + 1;
  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int CW = $clog2(((DW > MAX_LAYERS) ? DW : MAX_LAYERS) + 1);

  mal_pkg::state_t state_r, state_nxt;
  logic [CW-1:0]   cnt_r, cnt_nxt;

  // Next state
  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    case (state_r)
      mal_pkg::ST_IDLE: begin
        if (in_valid) state_nxt = mal_pkg::ST_DEC;
      end
      mal_pkg::ST_DEC: begin
        cnt_nxt = '0;
        if (sts.mix_req) state_nxt = mal_pkg::ST_READ;
        else if (sts.close_req && sts.snap) state_nxt = mal_pkg::ST_DIV;
        else if (sts.close_req) state_nxt = mal_pkg::ST_LEN;
        else state_nxt = mal_pkg::ST_FIN;
      end
      mal_pkg::ST_DIV: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(DW - 1)) state_nxt = mal_pkg::ST_LEN;
      end
      mal_pkg::ST_LEN: state_nxt = mal_pkg::ST_FIN;
      mal_pkg::ST_READ: begin
        cnt_nxt = cnt_r + CW'(1);
        if (cnt_r == CW'(MAX_LAYERS - 1)) state_nxt = mal_pkg::ST_ACC;
      end
      mal_pkg::ST_ACC: state_nxt = mal_pkg::ST_MUL;
      mal_pkg::ST_MUL: state_nxt = mal_pkg::ST_FIN;
      mal_pkg::ST_FIN: begin
        if (!sts.is_sample || sts.out_free) state_nxt = mal_pkg::ST_IDLE;
      end
      default: state_nxt = mal_pkg::ST_IDLE;
    endcase
  end

  // Outputs
  always_comb begin
    cmd          = '0;
    in_ready     = 1'b0;
    rd_idx       = cnt_r[LW-1:0];
    case (state_r)
      mal_pkg::ST_IDLE: begin
        in_ready = 1'b1;
        cmd.load = in_valid;
      end
      mal_pkg::ST_DEC: begin
        cmd.dec      = 1'b1;
        cmd.div_init = sts.close_req && sts.snap && !sts.mix_req;
      end
      mal_pkg::ST_DIV:  cmd.div_step = 1'b1;
      mal_pkg::ST_LEN:  cmd.len_en   = 1'b1;
      mal_pkg::ST_READ: cmd.rd_en    = 1'b1;
      mal_pkg::ST_ACC:  cmd          = '0;
      mal_pkg::ST_MUL:  cmd.mul_en   = 1'b1;
      mal_pkg::ST_FIN:  cmd.fin      = !sts.is_sample || sts.out_free;
      default:          cmd          = '0;
    endcase
  end

  // State registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= mal_pkg::ST_IDLE;
      cnt_r   <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
    end
  end

endmodule

/* design/mal_dp.sv */
module mal_dp #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_LEN    = 2097152,
  parameter int MIN_LEN    = 4800
) (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  mal_pkg::ctl_cmd_t                     cmd,
  input  logic [((MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1)-1:0] rd_idx,
  output mal_pkg::dp_sts_t                      sts,
  input  logic [mal_pkg::W_CMD-1:0]             in_cmd,
  input  logic signed [mal_pkg::W_SAMPLE-1:0]   in_sample_in,
  input  logic                                  cfg_valid,
  input  logic [mal_pkg::W_CFGIDX-1:0]          cfg_index,
  input  logic [mal_pkg::W_BAR-1:0]             cfg_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output logic signed [mal_pkg::W_AUDIO-1:0]    out_audio_out,
  output logic [mal_pkg::W_MODE-1:0]            out_mode,
  output logic [mal_pkg::W_LCNT-1:0]            out_layer_count,
  output logic [mal_pkg::W_POS-1:0]             out_position,
  output logic [mal_pkg::W_POS-1:0]             out_loop_length
);

  localparam int HW    = $clog2(MAX_LEN + 1);
  localparam int LCW   = $clog2(MAX_LAYERS + 1);
  localparam int LW    = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;
  localparam int DEPTH = MAX_LAYERS * MAX_LEN;
  localparam int AW    = $clog2(DEPTH);
  localparam int DW    = ((HW > mal_pkg::W_BAR) ? HW : mal_pkg::W_BAR) + 1;
  localparam int SW    = mal_pkg::W_SAMPLE + LW + 1;
  localparam int PW    = SW + mal_pkg::W_LEVEL + 1;
  localparam int YW    = PW - mal_pkg::MIX_FRAC + 1;
  localparam int PLW   = mal_pkg::W_BAR + DW;

  // Configuration
  logic [mal_pkg::W_LEVEL-1:0] level_r;
  logic [mal_pkg::W_BAR-1:0]   bar_r;
  logic [mal_pkg::W_BCNT-1:0]  bcnt_r;

  // Looper state
  mal_pkg::mode_t  mode_r, mode_nxt;
  logic [LCW-1:0]  layers_r, layers_nxt;
  logic [HW-1:0]   head_r, head_nxt;
  logic [HW-1:0]   len_r, len_nxt;
  logic [HW-1:0]   dstart_r, dstart_nxt;
  logic [HW-1:0]   dcount_r, dcount_nxt;
  logic            wrap_r, wrap_nxt;
  logic [HW-1:0]   vs_r [MAX_LAYERS];
  logic [HW-1:0]   ve_r [MAX_LAYERS];
  logic [HW-1:0]   vs_nxt [MAX_LAYERS];
  logic [HW-1:0]   ve_nxt [MAX_LAYERS];

  // Item and working registers
  logic [mal_pkg::W_CMD-1:0]           icmd_r;
  logic signed [mal_pkg::W_SAMPLE-1:0] isamp_r;
  logic [HW-1:0]                       raw_r;
  logic [DW-1:0]                       dvd_r;
  logic [mal_pkg::W_BAR-1:0]           rem_r;
  logic [PLW-1:0]                      plen_r;
  logic signed [mal_pkg::W_SAMPLE-1:0] rd_data_r;
  logic                                hit_r;
  logic                                acc_pend_r;
  logic signed [SW-1:0]                sum_r;
  logic signed [PW-1:0]                prod_r;

  // Memory
  logic signed [mal_pkg::W_SAMPLE-1:0] mem [DEPTH];

  logic [HW:0]                  head_inc;
  logic [mal_pkg::W_LEVEL-1:0]  gain;
  logic [mal_pkg::W_BAR:0]      div_rs;
  logic                         div_ge;
  logic [DW-1:0]                bars;
  logic [DW-1:0]                mul_b;
  logic [PLW-1:0]               len_pre;
  logic [HW-1:0]                close_len;
  logic [HW:0]                  dub_end;
  logic signed [PW-1:0]         prod_rnd;
  logic signed [PW-1:0]         mix_q;
  logic signed [YW-1:0]         y_full;
  logic signed [YW-1:0]         y_sat;
  logic                         do_close;
  logic                         do_commit;
  logic                         wr_en;
  logic [LW-1:0]                wr_layer;
  logic [AW-1:0]                wr_addr;
  logic [AW-1:0]                rd_addr;
  logic                         hit_nxt;
  logic [LCW-1:0]               layers_dec;
  logic [HW:0]                  dc_inc;

  assign head_inc = (HW + 1)'(head_r) + (HW + 1)'(1);
  assign gain = (level_r > mal_pkg::W_LEVEL'(mal_pkg::LEVEL_MAX)) ?
                mal_pkg::W_LEVEL'(mal_pkg::LEVEL_MAX) : level_r;

  // Decode the held item
  always_comb begin
    sts.is_sample = (icmd_r == mal_pkg::CMD_SAMPLE);
    sts.mix_req   = sts.is_sample &&
                    (mode_r == mal_pkg::MODE_PLAY || mode_r == mal_pkg::MODE_DUB);
    sts.close_req = (mode_r == mal_pkg::MODE_REC) &&
                    ((icmd_r == mal_pkg::CMD_PRESS) || (icmd_r == mal_pkg::CMD_STOP) ||
                     (sts.is_sample && head_inc >= (HW + 1)'(MAX_LEN)));
    sts.snap      = (bar_r != '0) && (bcnt_r == '0);
    sts.out_free  = !out_valid || out_ready;
  end

  // Bar snapping divider, one quotient bit a cycle
  assign div_rs = {rem_r, dvd_r[DW-1]};
  assign div_ge = div_rs >= {1'b0, bar_r};
  assign bars   = (dvd_r == '0) ? DW'(1) : dvd_r;
  assign mul_b  = (bcnt_r != '0) ? DW'(bcnt_r) : bars;

  // Clamp the first pass length
  always_comb begin
    len_pre = (bar_r == '0) ? PLW'(raw_r) : plen_r;
    if (len_pre > PLW'(MAX_LEN)) len_pre = PLW'(MAX_LEN);
    if (len_pre < PLW'(MIN_LEN)) len_pre = PLW'(MIN_LEN);
    close_len = HW'(len_pre);
  end

  // Layer window test for the read in flight
  assign hit_nxt = (LCW'(rd_idx) < layers_r) && (head_r >= vs_r[rd_idx]) &&
                   (head_r < ve_r[rd_idx]);
  assign rd_addr = AW'(rd_idx) * AW'(MAX_LEN) + AW'(head_r);
  assign wr_addr = AW'(wr_layer) * AW'(MAX_LEN) + AW'(head_r);

  // Scale the mix and add the dry input
  always_comb begin
    prod_rnd = prod_r + PW'(mal_pkg::MIX_ROUND);
    mix_q    = prod_rnd >>> mal_pkg::MIX_FRAC;
    y_full   = YW'(isamp_r) + YW'(mix_q);
  end

  assign dub_end    = (HW + 1)'(dstart_r) + (HW + 1)'(dcount_r);
  assign layers_dec = (layers_r != '0) ? layers_r - LCW'(1) : layers_r;
  assign dc_inc     = (HW + 1)'(dcount_r) + (HW + 1)'(1);

  // Apply the item to the looper state
  always_comb begin
    mode_nxt   = mode_r;
    layers_nxt = layers_r;
    head_nxt   = head_r;
    len_nxt    = len_r;
    dstart_nxt = dstart_r;
    dcount_nxt = dcount_r;
    wrap_nxt   = wrap_r;
    vs_nxt     = vs_r;
    ve_nxt     = ve_r;
    do_close   = 1'b0;
    do_commit  = 1'b0;
    wr_en      = 1'b0;
    wr_layer   = '0;
    y_sat      = YW'(isamp_r);
    case (icmd_r)
      mal_pkg::CMD_SAMPLE: begin
        if (mode_r == mal_pkg::MODE_REC) begin
          wr_en    = 1'b1;
          head_nxt = HW'(head_inc);
          if (head_inc >= (HW + 1)'(MAX_LEN)) begin
            do_close = 1'b1;
            mode_nxt = mal_pkg::MODE_PLAY;
          end
        end else if (mode_r == mal_pkg::MODE_PLAY || mode_r == mal_pkg::MODE_DUB) begin
          y_sat = y_full;
          if (y_full > YW'(mal_pkg::AUDIO_MAX)) y_sat = YW'(mal_pkg::AUDIO_MAX);
          if (y_full < YW'(mal_pkg::AUDIO_MIN)) y_sat = YW'(mal_pkg::AUDIO_MIN);
          if (mode_r == mal_pkg::MODE_DUB) begin
            wr_en      = layers_r < LCW'(MAX_LAYERS);
            wr_layer   = LW'(layers_r);
            dcount_nxt = HW'(dc_inc);
          end
          if (head_inc >= (HW + 1)'(len_r)) begin
            head_nxt = '0;
            if (mode_r == mal_pkg::MODE_DUB) wrap_nxt = 1'b1;
          end else begin
            head_nxt = HW'(head_inc);
          end
          if (mode_r == mal_pkg::MODE_DUB && dc_inc >= (HW + 1)'(len_r)) begin
            if (layers_r < LCW'(MAX_LAYERS)) begin
              vs_nxt[LW'(layers_r)] = '0;
              ve_nxt[LW'(layers_r)] = len_r;
              layers_nxt            = layers_r + LCW'(1);
            end
            mode_nxt = mal_pkg::MODE_PLAY;
          end
        end
      end
      mal_pkg::CMD_RESET: begin
        mode_nxt   = mal_pkg::MODE_EMPTY;
        layers_nxt = '0;
        len_nxt    = '0;
        head_nxt   = '0;
      end
      mal_pkg::CMD_PRESS: begin
        case (mode_r)
          mal_pkg::MODE_EMPTY: begin
            head_nxt = '0;
            mode_nxt = mal_pkg::MODE_REC;
          end
          mal_pkg::MODE_REC: begin
            do_close = 1'b1;
            mode_nxt = mal_pkg::MODE_PLAY;
          end
          mal_pkg::MODE_PLAY: begin
            if (layers_r < LCW'(MAX_LAYERS)) begin
              dstart_nxt = head_r;
              dcount_nxt = '0;
              wrap_nxt   = 1'b0;
              mode_nxt   = mal_pkg::MODE_DUB;
            end
          end
          mal_pkg::MODE_DUB: begin
            do_commit = 1'b1;
            mode_nxt  = mal_pkg::MODE_PLAY;
          end
          mal_pkg::MODE_STOP: begin
            head_nxt = '0;
            mode_nxt = mal_pkg::MODE_PLAY;
          end
          default: mode_nxt = mode_r;
        endcase
      end
      mal_pkg::CMD_STOP: begin
        case (mode_r)
          mal_pkg::MODE_REC: begin
            do_close = 1'b1;
            mode_nxt = mal_pkg::MODE_STOP;
          end
          mal_pkg::MODE_DUB: begin
            do_commit = 1'b1;
            head_nxt  = '0;
            mode_nxt  = mal_pkg::MODE_STOP;
          end
          mal_pkg::MODE_PLAY: begin
            head_nxt = '0;
            mode_nxt = mal_pkg::MODE_STOP;
          end
          default: mode_nxt = mode_r;
        endcase
      end
      mal_pkg::CMD_UNDO: begin
        case (mode_r)
          mal_pkg::MODE_DUB: mode_nxt = mal_pkg::MODE_PLAY;
          mal_pkg::MODE_REC: begin
            mode_nxt = mal_pkg::MODE_EMPTY;
            len_nxt  = '0;
            head_nxt = '0;
          end
          mal_pkg::MODE_PLAY, mal_pkg::MODE_STOP: begin
            layers_nxt = layers_dec;
            if (layers_dec == '0) begin
              mode_nxt = mal_pkg::MODE_EMPTY;
              len_nxt  = '0;
              head_nxt = '0;
            end
          end
          default: mode_nxt = mode_r;
        endcase
      end
      default: mode_nxt = mode_r;
    endcase

    // Close the first pass
    if (do_close) begin
      vs_nxt[0]  = '0;
      ve_nxt[0]  = raw_r;
      layers_nxt = LCW'(1);
      head_nxt   = '0;
      len_nxt    = close_len;
    end

    // Commit an overdub ended by hand
    if (do_commit && layers_r < LCW'(MAX_LAYERS)) begin
      if (wrap_r) begin
        vs_nxt[LW'(layers_r)] = '0;
        ve_nxt[LW'(layers_r)] = len_r;
      end else begin
        vs_nxt[LW'(layers_r)] = dstart_r;
        ve_nxt[LW'(layers_r)] = (dub_end > (HW + 1)'(len_r)) ? len_r : HW'(dub_end);
      end
      layers_nxt = layers_r + LCW'(1);
    end
  end

  // Layer store: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (cmd.fin && wr_en) mem[wr_addr] <= isamp_r;
    if (cmd.rd_en) rd_data_r <= mem[rd_addr];
  end

  // Working registers
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      icmd_r  <= in_cmd;
      isamp_r <= in_sample_in;
    end
    if (cmd.rd_en) hit_r <= hit_nxt;
    if (cmd.dec) begin
      sum_r <= '0;
      raw_r <= (icmd_r == mal_pkg::CMD_SAMPLE) ? HW'(head_inc) : head_r;
    end else if (acc_pend_r && hit_r) begin
      sum_r <= sum_r + SW'(rd_data_r);
    end
    if (cmd.div_init) begin
      rem_r <= '0;
      dvd_r <= DW'(head_r) + DW'(icmd_r == mal_pkg::CMD_SAMPLE) + DW'(bar_r >> 1);
    end else if (cmd.div_step) begin
      rem_r <= div_ge ? mal_pkg::W_BAR'(div_rs - {1'b0, bar_r}) : mal_pkg::W_BAR'(div_rs);
      dvd_r <= {dvd_r[DW-2:0], div_ge};
    end
    if (cmd.len_en) plen_r <= PLW'(bar_r) * PLW'(mul_b);
    if (cmd.mul_en) prod_r <= sum_r * $signed({1'b0, gain});
    if (cmd.fin && sts.is_sample) begin
      out_audio_out   <= mal_pkg::W_AUDIO'(y_sat);
      out_mode        <= mal_pkg::W_MODE'(mode_nxt);
      out_layer_count <= mal_pkg::W_LCNT'(layers_nxt);
      out_position    <= mal_pkg::W_POS'(head_nxt);
      out_loop_length <= mal_pkg::W_POS'(len_nxt);
    end
  end

  // Control and looper state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r    <= mal_pkg::W_LEVEL'(mal_pkg::LEVEL_RESET);
      bar_r      <= '0;
      bcnt_r     <= '0;
      mode_r     <= mal_pkg::MODE_EMPTY;
      layers_r   <= '0;
      head_r     <= '0;
      len_r      <= '0;
      dstart_r   <= '0;
      dcount_r   <= '0;
      wrap_r     <= 1'b0;
      acc_pend_r <= 1'b0;
      out_valid  <= 1'b0;
      for (int i = 0; i < MAX_LAYERS; i++) begin
        vs_r[i] <= '0;
        ve_r[i] <= '0;
      end
    end else begin
      acc_pend_r <= cmd.rd_en;
      if (cfg_valid) begin
        case (cfg_index)
          mal_pkg::CFG_LEVEL: level_r <= mal_pkg::W_LEVEL'(cfg_data);
          mal_pkg::CFG_BAR:   bar_r   <= cfg_data;
          mal_pkg::CFG_BCNT:  bcnt_r  <= mal_pkg::W_BCNT'(cfg_data);
          default:            bar_r   <= bar_r;
        endcase
      end
      if (cmd.fin) begin
        mode_r   <= mode_nxt;
        layers_r <= layers_nxt;
        head_r   <= head_nxt;
        len_r    <= len_nxt;
        dstart_r <= dstart_nxt;
        dcount_r <= dcount_nxt;
        wrap_r   <= wrap_nxt;
        vs_r     <= vs_nxt;
        ve_r     <= ve_nxt;
      end
      // Hold the result beat until taken
      if (cmd.fin && sts.is_sample) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

endmodule

/* design/multilayer_audio_looper.sv */
// A play or overdub sample beat is decoded, read from the store once per layer, accumulated,
// scaled and finished, and its result registered at the output; other beats go from decode
// to finish, via the length step on closing the first pass and also via the bar divider
// (one quotient bit per cycle) when the close snaps to bars. One item is in work at a time.
// Reset: synchronous active-low rst_n clears mode, layers, head, length and windows;
// the layer store is not cleared and its entries are undefined until written.
module multilayer_audio_looper #(
  parameter int MAX_LAYERS = 8,
  parameter int MAX_LEN    = 2097152,
  parameter int MIN_LEN    = 4800
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_ready,
  input  logic [mal_pkg::W_CMD-1:0]           in_cmd,
  input  logic signed [mal_pkg::W_SAMPLE-1:0] in_sample_in,
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic signed [mal_pkg::W_AUDIO-1:0]  out_audio_out,
  output logic [mal_pkg::W_MODE-1:0]          out_mode,
  output logic [mal_pkg::W_LCNT-1:0]          out_layer_count,
  output logic [mal_pkg::W_POS-1:0]           out_position,
  output logic [mal_pkg::W_POS-1:0]           out_loop_length,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [mal_pkg::W_CFGIDX-1:0]        cfg_index,
  input  logic [mal_pkg::W_BAR-1:0]           cfg_data
);

  localparam int LW = (MAX_LAYERS > 1) ? $clog2(MAX_LAYERS) : 1;

  mal_pkg::ctl_cmd_t cmd;
  mal_pkg::dp_sts_t  sts;
  logic [LW-1:0]     rd_idx;

  assign cfg_ready = 1'b1;

  mal_ctrl #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_LEN    (MAX_LEN)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .sts      (sts),
    .cmd      (cmd),
    .rd_idx   (rd_idx)
  );

  mal_dp #(
    .MAX_LAYERS (MAX_LAYERS),
    .MAX_LEN    (MAX_LEN),
    .MIN_LEN    (MIN_LEN)
  ) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .cmd             (cmd),
    .rd_idx          (rd_idx),
    .sts             (sts),
    .in_cmd          (in_cmd),
    .in_sample_in    (in_sample_in),
    .cfg_valid       (cfg_valid),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_audio_out   (out_audio_out),
    .out_mode        (out_mode),
    .out_layer_count (out_layer_count),
    .out_position    (out_position),
    .out_loop_length (out_loop_length)
  );

  // An accepted beat takes the block out of idle
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("input ready held after accept");

  // A finished sample always presents a result
  a_result_after_fin: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.fin && sts.is_sample) |=> out_valid)
    else $error("result missing after sample finish");

  // Store reads only happen while an item is in work
  a_read_only_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_ready |-> !(cmd.rd_en || cmd.fin))
    else $error("datapath active while idle");

endmodule
